@@ hw/rtl/gmah_pkg.sv @@
// Shared constants and types for the gated moving average with hysteresis gate.
// Used by the top level and the bench; depends on nothing.
package gmah_pkg;

  localparam int unsigned MaxWindow = 16;
  localparam int unsigned SampleW   = 15;
  localparam int unsigned SlotW     = $clog2(MaxWindow);
  localparam int unsigned FillW     = $clog2(MaxWindow + 1);
  localparam int unsigned SumW      = SampleW + SlotW;
  localparam int unsigned AvgW      = SumW + 1;
  localparam int unsigned LenW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned DivCntW   = $clog2(SumW);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegOrbitCw   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindowLen = 2'd1;

  // Angles in degrees times 128
  localparam int HardNear = 2560;
  localparam int HardFar  = 10240;
  localparam int Buffer   = 512;

  localparam logic [LenW-1:0] WindowLenReset = 5'd5;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic signed [AvgW-1:0]    avg_t;

endpackage

@@ hw/rtl/gated_moving_average_hysteresis_unit.sv @@
// Gated moving average of angle samples (degrees x 128) with a hysteresis gate.
// Uses gmah_pkg and one gmah_ram instance for the sample history.
//
// Each accepted word is checked against the hard window (-80..-20 deg when
// orbit_clockwise is set, else 20..80 deg) and zeroed if outside, pushed into
// a history of up to 16 samples held in a RAM, and averaged by the fill count
// (truncated toward zero). From acceptance until its result is offered, a word
// passes these steps in order: a read of the oldest sample from the history RAM,
// an update of the running sum with a write of the new sample, a bit-serial
// divider, and a step that settles the gate and loads the output register.
// The next word is accepted in the cycle after that, so a new word is never
// taken before the last one is through. A result still waiting in the output
// register holds the following word in its last step, and no further word is
// accepted until that result is taken. The history needs no clearing pass:
// only entries already written are ever read back.
module gated_moving_average_hysteresis_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [gmah_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gmah_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [14:0] angle_sample
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [14:0] filtered_angle
  output logic                        m_axis_tuser   // [0] gate_on
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StUpdate,
    StDivide,
    StOutput
  } state_e;

  state_e                           state_q;
  logic                             orbit_cw_q;
  logic [gmah_pkg::LenW-1:0]        win_len_q;
  gmah_pkg::sample_t                sample_q;
  logic                             drop_q;
  gmah_pkg::sum_t                   sum_q;
  logic [gmah_pkg::FillW-1:0]       fill_q;
  logic [gmah_pkg::SlotW-1:0]       slot_q;
  logic                             gate_q;
  logic                             neg_q;
  logic [gmah_pkg::SumW-1:0]        dvd_q;
  logic [gmah_pkg::FillW-1:0]       rem_q;
  logic [gmah_pkg::DivCntW-1:0]     cnt_q;
  logic                             out_valid_q;
  gmah_pkg::sample_t                out_angle_q;
  logic                             out_gate_q;

  gmah_pkg::avg_t                   lo, hi;
  gmah_pkg::sample_t                in_sample, gated_sample;
  logic [gmah_pkg::FillW-1:0]       eff_len;
  logic                             accept, out_take;
  logic [gmah_pkg::SlotW-1:0]       oldest;
  gmah_pkg::sample_t                old_sample;
  logic [gmah_pkg::SumW:0]          sum_wide;
  gmah_pkg::sum_t                   sum_d;
  logic [gmah_pkg::SumW-1:0]        sum_mag;
  logic [gmah_pkg::FillW:0]         trial;
  logic                             qbit;
  logic [gmah_pkg::FillW-1:0]       rem_d;
  gmah_pkg::avg_t                   avg;
  logic                             gate_d;

  assign lo = orbit_cw_q ? gmah_pkg::avg_t'(-gmah_pkg::HardFar)
                         : gmah_pkg::avg_t'(gmah_pkg::HardNear);
  assign hi = orbit_cw_q ? gmah_pkg::avg_t'(-gmah_pkg::HardNear)
                         : gmah_pkg::avg_t'(gmah_pkg::HardFar);

  assign in_sample = gmah_pkg::sample_t'(s_axis_tdata[gmah_pkg::SampleW-1:0]);
  always_comb begin
    gated_sample = in_sample;
    if (gmah_pkg::avg_t'(in_sample) < lo || gmah_pkg::avg_t'(in_sample) > hi) begin
      gated_sample = '0;
    end
  end

  // Zero acts as one, anything past the history depth saturates
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = gmah_pkg::FillW'(1);
    end else if (win_len_q > gmah_pkg::LenW'(gmah_pkg::MaxWindow)) begin
      eff_len = gmah_pkg::FillW'(gmah_pkg::MaxWindow);
    end else begin
      eff_len = gmah_pkg::FillW'(win_len_q);
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // A full history wraps the oldest slot onto the write slot; the read comes first
  assign oldest = slot_q - fill_q[gmah_pkg::SlotW-1:0];

  gmah_ram #(
    .Width(gmah_pkg::SampleW),
    .Depth(gmah_pkg::MaxWindow)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (state_q == StUpdate),
    .waddr_i(slot_q),
    .wdata_i(sample_q),
    .raddr_i(oldest),
    .rdata_o(old_sample)
  );

  always_comb begin
    sum_wide = {sum_q[gmah_pkg::SumW-1], sum_q}
             + {{(gmah_pkg::SumW + 1 - gmah_pkg::SampleW){sample_q[gmah_pkg::SampleW-1]}},
                sample_q};
    if (drop_q) begin
      sum_wide = sum_wide
               - {{(gmah_pkg::SumW + 1 - gmah_pkg::SampleW){old_sample[gmah_pkg::SampleW-1]}},
                  old_sample};
    end
    sum_d   = gmah_pkg::sum_t'(sum_wide[gmah_pkg::SumW-1:0]);
    sum_mag = sum_d[gmah_pkg::SumW-1] ? gmah_pkg::SumW'(-sum_d) : gmah_pkg::SumW'(sum_d);
  end

  // One restoring step per cycle; the quotient shifts in behind the dividend
  always_comb begin
    trial = {rem_q, dvd_q[gmah_pkg::SumW-1]};
    qbit  = (trial >= {1'b0, fill_q});
    rem_d = qbit ? gmah_pkg::FillW'(trial - {1'b0, fill_q})
                 : trial[gmah_pkg::FillW-1:0];
  end

  always_comb begin
    avg = neg_q ? -gmah_pkg::avg_t'({1'b0, dvd_q}) : gmah_pkg::avg_t'({1'b0, dvd_q});
    gate_d = gate_q;
    if (gate_q) begin
      if (avg > hi + gmah_pkg::avg_t'(gmah_pkg::Buffer) ||
          avg < lo - gmah_pkg::avg_t'(gmah_pkg::Buffer)) begin
        gate_d = 1'b0;
      end
    end else begin
      if (avg <= hi - gmah_pkg::avg_t'(gmah_pkg::Buffer) &&
          avg >= lo + gmah_pkg::avg_t'(gmah_pkg::Buffer)) begin
        gate_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      orbit_cw_q  <= 1'b1;
      win_len_q   <= gmah_pkg::WindowLenReset;
      sample_q    <= '0;
      drop_q      <= 1'b0;
      sum_q       <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      gate_q      <= 1'b0;
      neg_q       <= 1'b0;
      dvd_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_angle_q <= '0;
      out_gate_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gmah_pkg::RegOrbitCw:   orbit_cw_q <= cfg_data_i[0];
          gmah_pkg::RegWindowLen: win_len_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // The output step refills the register itself when it is taken
      if (out_take && state_q != StOutput) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            sample_q <= gated_sample;
            drop_q   <= !(fill_q < eff_len);
            if (fill_q < eff_len) begin
              fill_q <= fill_q + gmah_pkg::FillW'(1);
            end
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StUpdate;
        end
        StUpdate: begin
          sum_q   <= sum_d;
          slot_q  <= slot_q + gmah_pkg::SlotW'(1);
          neg_q   <= sum_d[gmah_pkg::SumW-1];
          dvd_q   <= sum_mag;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StDivide;
        end
        StDivide: begin
          dvd_q <= {dvd_q[gmah_pkg::SumW-2:0], qbit};
          rem_q <= rem_d;
          cnt_q <= cnt_q + gmah_pkg::DivCntW'(1);
          if (cnt_q == gmah_pkg::DivCntW'(gmah_pkg::SumW - 1)) begin
            state_q <= StOutput;
          end
        end
        StOutput: begin
          // Hold until the output register is free
          if (!out_valid_q || out_take) begin
            gate_q      <= gate_d;
            out_valid_q <= 1'b1;
            out_gate_q  <= gate_d;
            out_angle_q <= gate_d ? avg[gmah_pkg::SampleW-1:0] : '0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_angle_q};
  assign m_axis_tuser  = out_gate_q;

endmodule

@@ hw/rtl/gmah_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module gmah_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gmah_checker.sv @@
// Port-level checks for gated_moving_average_hysteresis_unit, bound to the top.
// Stand-alone; watches only the stream handshakes and the result word.
module gmah_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [15:0]                   m_axis_tdata,
  input logic                          m_axis_tuser
);

  // A stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A closed gate always reports a zero angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("nonzero angle with gate off");

  // An open gate never passes a zero average
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[14:0] != 15'd0)
    else $error("zero angle with gate on");

  // One word at a time: no second accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

endmodule

bind gated_moving_average_hysteresis_unit gmah_checker u_gmah_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for gated_moving_average_hysteresis_unit: streams angle words
// through the block and checks every result against an in-bench window/gate predictor.
// Depends on gmah_pkg and the unit's RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // no register sits behind this index; writes to it must be ignored
  localparam logic [gmah_pkg::CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct {
    gmah_pkg::sample_t filtered;
    logic              gate_on;
  } filter_result_t;

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [gmah_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [gmah_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata  = '0;  // [14:0] angle_sample
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;        // [14:0] filtered_angle
  logic                          m_axis_tuser;        // [0] gate_on

  gated_moving_average_hysteresis_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state and register shadows
  gmah_pkg::sample_t               angle_history [gmah_pkg::MaxWindow];
  gmah_pkg::sum_t                  angle_total   = '0;
  logic [gmah_pkg::FillW-1:0]      held_count    = '0;
  logic [gmah_pkg::SlotW-1:0]      next_slot     = '0;
  bit                              gate_open     = 1'b0;
  bit                              orbit_cw      = 1'b1;
  logic [gmah_pkg::LenW-1:0]       win_len       = gmah_pkg::WindowLenReset;

  gmah_pkg::sample_t angle_backlog[$];
  filter_result_t    predicted_results[$];

  bit word_taken     = 1'b0;
  bit result_taken   = 1'b0;
  bit tx_no_idle     = 1'b0;
  bit rx_no_idle     = 1'b0;
  int hold_requests  = 0;
  int error_count    = 0;
  int result_count   = 0;
  int issued_count   = 0;
  int accepted_count = 0;

  initial begin
    foreach (angle_history[i]) angle_history[i] = '0;
  end

  function automatic int draw_gap(bit no_idle);
    return no_idle ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic filter_result_t filter_step(gmah_pkg::sample_t raw);
    gmah_pkg::sample_t kept;
    int                lo, hi, span, avg;
    filter_result_t    res;
    lo   = orbit_cw ? -gmah_pkg::HardFar : gmah_pkg::HardNear;
    hi   = orbit_cw ? -gmah_pkg::HardNear : gmah_pkg::HardFar;
    span = (win_len == 0) ? 1 : ((win_len > gmah_pkg::MaxWindow) ? int'(gmah_pkg::MaxWindow)
                                                                  : int'(win_len));
    kept = (raw < lo || raw > hi) ? gmah_pkg::sample_t'(0) : raw;
    // once full, drop the oldest held sample; a shrunk window keeps its fill
    if (int'(held_count) < span) held_count++;
    else angle_total = angle_total
                     - angle_history[gmah_pkg::SlotW'(next_slot - held_count)];
    angle_history[next_slot] = kept;
    angle_total = angle_total + kept;
    next_slot++;
    avg = int'(angle_total) / int'(held_count);
    if (gate_open) begin
      if (avg > hi + gmah_pkg::Buffer || avg < lo - gmah_pkg::Buffer) gate_open = 1'b0;
    end else begin
      if (avg <= hi - gmah_pkg::Buffer && avg >= lo + gmah_pkg::Buffer) gate_open = 1'b1;
    end
    res.filtered = gate_open ? gmah_pkg::sample_t'(avg) : gmah_pkg::sample_t'(0);
    res.gate_on  = gate_open;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] mismatch on %s at result %0d: got %0d, want %0d",
             $realtime, what, result_count, got, want);
  endtask

  // sender: hold the word until taken, then idle for the drawn gap
  always @(negedge clk_i) begin : sender
    logic        vld;
    logic [15:0] dat;
    int          gap_left;
    vld = s_axis_tvalid;
    dat = s_axis_tdata;
    if (rst_ni && (!vld || word_taken)) begin
      vld = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (angle_backlog.size() > 0) begin
        dat      = {1'b0, angle_backlog.pop_front()};
        vld      = 1'b1;
        gap_left = draw_gap(tx_no_idle);
      end
    end
    s_axis_tvalid <= vld;
    s_axis_tdata  <= dat;
  end

  // receiver: random stall after each result, long hold-off on request
  always @(negedge clk_i) begin : receiver
    int  stall_left;
    int  hold_left;
    int  holds_served;
    logic rdy;
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (result_taken) stall_left = draw_gap(rx_no_idle);
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin : monitor
    filter_result_t want;
    word_taken   <= s_axis_tvalid && s_axis_tready;
    result_taken <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result",
                          int'(gmah_pkg::sample_t'(m_axis_tdata[14:0])), 0);
        end else begin
          want = predicted_results.pop_front();
          if (m_axis_tdata[14:0] !== want.filtered)
            report_mismatch("filtered_angle",
                            int'(gmah_pkg::sample_t'(m_axis_tdata[14:0])),
                            int'(want.filtered));
          if (m_axis_tuser !== want.gate_on)
            report_mismatch("gate_on", int'(m_axis_tuser), int'(want.gate_on));
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_results.insert(predicted_results.size(),
                                 filter_step(gmah_pkg::sample_t'(s_axis_tdata[14:0])));
        accepted_count++;
      end
    end
  end

  task automatic write_reg(logic [gmah_pkg::CfgIdxW-1:0] idx,
                           logic [gmah_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gmah_pkg::RegOrbitCw) orbit_cw = val[0];
    else if (idx == gmah_pkg::RegWindowLen) win_len = val;
  endtask

  function automatic void queue_angle(gmah_pkg::sample_t angle);
    angle_backlog.insert(angle_backlog.size(), angle);
    issued_count++;
  endfunction

  // wait until every word is taken and every result has come back
  task automatic drain();
    while (accepted_count != issued_count || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  function automatic gmah_pkg::sample_t draw_angle();
    int pick, mag;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      mag = int'($urandom_range(gmah_pkg::HardNear, gmah_pkg::HardFar));
    end else if (pick < 75) begin
      // around the window edges, inside and outside the gate margin
      mag = ($urandom_range(0, 1) ? gmah_pkg::HardNear : gmah_pkg::HardFar)
          + int'($urandom_range(0, 1100)) - 550;
    end else if (pick < 85) begin
      return gmah_pkg::sample_t'(int'($urandom_range(0, 23040)) - 11520);
    end else if (pick < 93) begin
      return gmah_pkg::sample_t'($urandom);
    end else begin
      mag = -int'($urandom_range(gmah_pkg::HardNear, gmah_pkg::HardFar));
    end
    return orbit_cw ? gmah_pkg::sample_t'(-mag) : gmah_pkg::sample_t'(mag);
  endfunction

  task automatic run_random(int count);
    repeat (count) queue_angle(draw_angle());
    drain();
  endtask

  initial begin : stimulus
    int opening_angles[16];
    int short_window_angles[4];
    opening_angles = '{-11520, 11520, -16384, 16383, 0, -10241, -2559, 2560,
                       10240, -10240, -2560, -6400, -6400, -6400, -6400, -6400};
    short_window_angles = '{-3072, 11520, -9728, -10240};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: clockwise window, five samples
    foreach (opening_angles[i]) queue_angle(gmah_pkg::sample_t'(opening_angles[i]));
    drain();

    // zero length acts as one; only bit 0 of the direction counts
    write_reg(gmah_pkg::RegWindowLen, 5'd0);
    write_reg(gmah_pkg::RegOrbitCw, 5'b11111);
    foreach (short_window_angles[i])
      queue_angle(gmah_pkg::sample_t'(short_window_angles[i]));
    drain();

    write_reg(gmah_pkg::RegOrbitCw, 5'd0);
    write_reg(gmah_pkg::RegWindowLen, 5'd31);
    run_random(90);

    tx_no_idle = 1'b1;
    write_reg(gmah_pkg::RegWindowLen, 5'd3);
    run_random(90);
    tx_no_idle = 1'b0;

    write_reg(RegSpare, 5'b11111);
    write_reg(gmah_pkg::RegWindowLen, 5'd16);
    hold_requests++;
    run_random(90);

    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    write_reg(gmah_pkg::RegOrbitCw, 5'd1);
    write_reg(gmah_pkg::RegWindowLen, 5'd1);
    run_random(90);
    tx_no_idle = 1'b0;

    write_reg(gmah_pkg::RegOrbitCw, 5'b11110);
    write_reg(gmah_pkg::RegWindowLen, 5'd8);
    run_random(90);
    rx_no_idle = 1'b0;

    write_reg(gmah_pkg::RegWindowLen, 5'd17);
    hold_requests++;
    run_random(90);

    write_reg(gmah_pkg::RegOrbitCw, 5'd1);
    write_reg(gmah_pkg::RegWindowLen, 5'd2);
    run_random(90);

    repeat (30) @(negedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gmah_pkg.sv
hw/rtl/gmah_ram.sv
hw/rtl/gated_moving_average_hysteresis_unit.sv
hw/rtl/gmah_checker.sv
bench/tb.sv
